[design/iesm_pkg.sv]
// Shared types and constants for the I/O expander shadow manager.
// Used by the channel interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package iesm_pkg;

  localparam int unsigned PORT_COUNT_DEF = 16;
  localparam int unsigned WORD_W         = 16;
  localparam int unsigned PORT_W         = 5;
  localparam int unsigned TIME_W         = 48;
  localparam int unsigned POLL_W         = 20;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 20;

  localparam logic [POLL_W-1:0] POLL_RESET = 20'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_OUTPUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_INTERRUPT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL  = 2'd2;

  typedef enum logic [2:0] {
    OP_CLAIM      = 3'd0,
    OP_WRITE      = 3'd1,
    OP_READ       = 3'd2,
    OP_BUS_TURN   = 3'd3,
    OP_INPUT_RX   = 3'd4,
    OP_SET_ENABLE = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_BAD_PORT = 2'd2
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [PORT_W-1:0] port;
    logic              as_output;
    logic              level;
    logic              enable;
    logic [WORD_W-1:0] input_word;
    logic              read_ok;
    logic              interrupt_low;
    logic [TIME_W-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic              read_level;
    logic              dir_write_valid;
    logic [WORD_W-1:0] dir_write_value;
    logic              out_write_valid;
    logic [WORD_W-1:0] out_write_value;
    logic              read_request;
    logic              bus_busy;
  } result_t;

endpackage

[design/iesm_in_if.sv]
// Input channel of the shadow manager: valid, ready and one operation beat.
// Depends on iesm_pkg for the field widths.
`timescale 1ns / 1ps

interface iesm_in_if import iesm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [PORT_W-1:0] port;
  logic              as_output;
  logic              level;
  logic              enable;
  logic [WORD_W-1:0] input_word;
  logic              read_ok;
  logic              interrupt_low;
  logic [TIME_W-1:0] now_us;

  modport source (
    output valid, op, port, as_output, level, enable, input_word, read_ok,
           interrupt_low, now_us,
    input  ready
  );

  modport sink (
    input  valid, op, port, as_output, level, enable, input_word, read_ok,
           interrupt_low, now_us,
    output ready
  );
endinterface

[design/iesm_out_if.sv]
// Result channel of the shadow manager: valid, ready and one result beat.
// Depends on iesm_pkg for the field widths.
`timescale 1ns / 1ps

interface iesm_out_if import iesm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              read_level;
  logic              dir_write_valid;
  logic [WORD_W-1:0] dir_write_value;
  logic              out_write_valid;
  logic [WORD_W-1:0] out_write_value;
  logic              read_request;
  logic              bus_busy;

  modport source (
    output valid, status, read_level, dir_write_valid, dir_write_value,
           out_write_valid, out_write_value, read_request, bus_busy,
    input  ready
  );

  modport sink (
    input  valid, status, read_level, dir_write_valid, dir_write_value,
           out_write_valid, out_write_value, read_request, bus_busy,
    output ready
  );
endinterface

[design/iesm_cfg_if.sv]
// Configuration write channel: valid, ready, register index and write data.
// Depends on iesm_pkg for the field widths.
`timescale 1ns / 1ps

interface iesm_cfg_if import iesm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/io_expander_shadow_manager_top.sv]
// Top level of the I/O expander shadow manager: claims, port access, bus turns.
// Depends on iesm_pkg and the three channel interfaces.
`timescale 1ns / 1ps

// It takes one operation beat per cycle unless the result channel stalls,
// and returns exactly one result beat for it: the beat is captured in an input
// register, the shadow words are updated and the result is computed when that
// register advances, and the result waits in an output register until it is
// taken. This sustained rate is set by the single update stage that reads and
// writes the shadow state. Configuration writes are taken at any time (ready
// is always high) but are meant for idle periods only.

module io_expander_shadow_manager_top
  import iesm_pkg::*;
#(
  parameter int unsigned PORT_COUNT = PORT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  iesm_in_if.sink     in_bus,
  iesm_out_if.source  out_bus,
  iesm_cfg_if.sink    cfg_bus
);

  localparam int unsigned PC = PORT_COUNT;

  logic          s1_valid_r, s1_valid_nxt;
  in_item_t      s1_r;
  logic          out_valid_r, out_valid_nxt;
  result_t       res_r, res_nxt;

  logic [PC-1:0] claimed_r, claimed_nxt;
  logic [PC-1:0] claimed_out_r, claimed_out_nxt;
  logic [PC-1:0] port_modes_r, port_modes_nxt;
  logic          outputs_on_r, outputs_on_nxt;
  logic [PC-1:0] dir_pending_r, dir_pending_nxt;
  logic [PC-1:0] dir_sent_r, dir_sent_nxt;
  logic [PC-1:0] out_pending_r, out_pending_nxt;
  logic [PC-1:0] out_sent_r, out_sent_nxt;
  logic [PC-1:0] input_image_r, input_image_nxt;
  logic [TIME_W-1:0] next_read_r, next_read_nxt;
  logic          use_int_r, use_int_nxt;
  logic [POLL_W-1:0] poll_r, poll_nxt;

  logic          s1_adv;
  logic          in_ready;
  logic          s1_fire;
  logic          cfg_fire;
  in_item_t      in_item;
  logic [PC-1:0] bitm;
  logic          in_range;
  logic          conflict;
  logic [PC-1:0] modes_claim;
  logic [PC-1:0] read_src;
  logic          rd;
  logic [TIME_W-1:0] next_time;

  assign s1_adv   = !out_valid_r || out_bus.ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign cfg_fire = cfg_bus.valid && cfg_bus.ready;

  assign in_bus.ready  = in_ready;
  assign cfg_bus.ready = 1'b1;

  assign in_item.op            = op_t'(in_bus.op);
  assign in_item.port          = in_bus.port;
  assign in_item.as_output     = in_bus.as_output;
  assign in_item.level         = in_bus.level;
  assign in_item.enable        = in_bus.enable;
  assign in_item.input_word    = in_bus.input_word;
  assign in_item.read_ok       = in_bus.read_ok;
  assign in_item.interrupt_low = in_bus.interrupt_low;
  assign in_item.now_us        = in_bus.now_us;

  always_comb begin
    for (int i = 0; i < PC; i++) begin
      bitm[i] = (s1_r.port == PORT_W'(i));
    end
  end

  assign in_range    = |bitm;
  assign conflict    = |(claimed_r & bitm) && (s1_r.as_output || |(claimed_out_r & bitm));
  assign modes_claim = s1_r.as_output ? (port_modes_r & ~bitm) : (port_modes_r | bitm);
  assign read_src    = (dir_sent_r & input_image_r) | (~dir_sent_r & out_sent_r);
  assign rd          = use_int_r ? s1_r.interrupt_low : (s1_r.now_us >= next_read_r);
  assign next_time   = s1_r.now_us + TIME_W'(poll_r);

  always_comb begin
    s1_valid_nxt    = in_ready ? in_bus.valid : s1_valid_r;
    out_valid_nxt   = s1_adv ? s1_valid_r : out_valid_r;
    res_nxt         = '0;
    claimed_nxt     = claimed_r;
    claimed_out_nxt = claimed_out_r;
    port_modes_nxt  = port_modes_r;
    outputs_on_nxt  = outputs_on_r;
    dir_pending_nxt = dir_pending_r;
    dir_sent_nxt    = dir_sent_r;
    out_pending_nxt = out_pending_r;
    out_sent_nxt    = out_sent_r;
    input_image_nxt = input_image_r;
    next_read_nxt   = next_read_r;
    use_int_nxt     = use_int_r;
    poll_nxt        = poll_r;

    if (s1_fire) begin
      unique case (s1_r.op)
        OP_CLAIM: begin
          if (!in_range) begin
            res_nxt.status = ST_BAD_PORT;
          end else if (conflict) begin
            res_nxt.status = ST_CONFLICT;
          end else begin
            claimed_nxt     = claimed_r | bitm;
            claimed_out_nxt = s1_r.as_output ? (claimed_out_r | bitm)
                                             : (claimed_out_r & ~bitm);
            port_modes_nxt  = modes_claim;
            if (outputs_on_r) begin
              dir_pending_nxt = modes_claim;
            end
          end
        end
        OP_WRITE: begin
          out_pending_nxt = s1_r.level ? (out_pending_r | bitm) : (out_pending_r & ~bitm);
        end
        OP_READ: begin
          res_nxt.read_level = |(bitm & read_src);
        end
        OP_BUS_TURN: begin
          if (dir_pending_r != dir_sent_r) begin
            dir_sent_nxt            = dir_pending_r;
            res_nxt.dir_write_valid = 1'b1;
            res_nxt.dir_write_value = WORD_W'(dir_pending_r);
          end
          if (out_pending_r != out_sent_r) begin
            out_sent_nxt            = out_pending_r;
            res_nxt.out_write_valid = 1'b1;
            res_nxt.out_write_value = WORD_W'(out_pending_r);
          end
          if (rd) begin
            res_nxt.read_request = 1'b1;
            next_read_nxt        = next_time;
          end
          res_nxt.bus_busy = (dir_pending_r != dir_sent_r) ||
                             (out_pending_r != out_sent_r) || rd;
        end
        OP_INPUT_RX: begin
          if (s1_r.read_ok) begin
            input_image_nxt = PC'(s1_r.input_word);
          end
        end
        OP_SET_ENABLE: begin
          outputs_on_nxt  = s1_r.enable;
          dir_pending_nxt = s1_r.enable ? port_modes_r : '1;
        end
        default: begin
        end
      endcase
    end

    if (cfg_fire) begin
      unique case (cfg_bus.index)
        CFG_INITIAL_OUTPUT: begin
          out_pending_nxt = PC'(cfg_bus.data[WORD_W-1:0]);
          out_sent_nxt    = PC'(cfg_bus.data[WORD_W-1:0]);
        end
        CFG_USE_INTERRUPT: begin
          use_int_nxt = cfg_bus.data[0];
        end
        CFG_POLL_INTERVAL: begin
          poll_nxt = cfg_bus.data[POLL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      claimed_r     <= '0;
      claimed_out_r <= '0;
      port_modes_r  <= '1;
      outputs_on_r  <= 1'b0;
      dir_pending_r <= '1;
      dir_sent_r    <= '1;
      out_pending_r <= '0;
      out_sent_r    <= '0;
      input_image_r <= '0;
      next_read_r   <= '0;
      use_int_r     <= 1'b0;
      poll_r        <= POLL_RESET;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      claimed_r     <= claimed_nxt;
      claimed_out_r <= claimed_out_nxt;
      port_modes_r  <= port_modes_nxt;
      outputs_on_r  <= outputs_on_nxt;
      dir_pending_r <= dir_pending_nxt;
      dir_sent_r    <= dir_sent_nxt;
      out_pending_r <= out_pending_nxt;
      out_sent_r    <= out_sent_nxt;
      input_image_r <= input_image_nxt;
      next_read_r   <= next_read_nxt;
      use_int_r     <= use_int_nxt;
      poll_r        <= poll_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_bus.valid) begin
      s1_r <= in_item;
    end
    if (s1_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.status          = res_r.status;
  assign out_bus.read_level      = res_r.read_level;
  assign out_bus.dir_write_valid = res_r.dir_write_valid;
  assign out_bus.dir_write_value = res_r.dir_write_value;
  assign out_bus.out_write_valid = res_r.out_write_valid;
  assign out_bus.out_write_value = res_r.out_write_value;
  assign out_bus.read_request    = res_r.read_request;
  assign out_bus.bus_busy        = res_r.bus_busy;

endmodule

[tb/io_expander_shadow_manager_checker.sv]
`timescale 1ns / 1ps
// Checker for the I/O expander shadow manager: it mirrors the claims, shadow words,
// input image and poll timer, and compares each result beat with its prediction.
// Depends on iesm_pkg and the three channel interfaces.

module io_expander_shadow_manager_checker
  import iesm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  iesm_in_if          in_mon,
  iesm_out_if         out_mon,
  iesm_cfg_if         cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int unsigned NPORTS = PORT_COUNT_DEF;
  localparam logic [WORD_W-1:0] ALL_INPUTS = '1;

  logic              use_irq;
  logic [POLL_W-1:0] poll_us;
  logic [WORD_W-1:0] claimed;
  logic [WORD_W-1:0] claimed_out;
  logic [WORD_W-1:0] port_modes;
  logic              outputs_on;
  logic [WORD_W-1:0] dir_pending;
  logic [WORD_W-1:0] dir_sent;
  logic [WORD_W-1:0] out_pending;
  logic [WORD_W-1:0] out_sent;
  logic [WORD_W-1:0] input_image;
  logic [TIME_W-1:0] next_read_us;

  result_t     results_due[$];
  int unsigned errs = 0;
  int unsigned due_count = 0;

  assign fail_count = errs;
  assign pending    = due_count;

  function automatic result_t shadow_step(in_item_t it);
    result_t           r;
    logic              in_range;
    logic              due;
    logic [PORT_W-1:0] p;
    r = '0;
    r.status = ST_OK;
    p = it.port;
    in_range = (32'(it.port) < NPORTS);
    case (it.op)
      OP_CLAIM: begin
        if (!in_range) begin
          r.status = ST_BAD_PORT;
        end else if (claimed[p] && (it.as_output || claimed_out[p])) begin
          r.status = ST_CONFLICT;
        end else begin
          claimed[p] = 1'b1;
          claimed_out[p] = it.as_output;
          port_modes[p] = ~it.as_output;
          if (outputs_on) dir_pending = port_modes;
        end
      end
      OP_WRITE: begin
        if (in_range) out_pending[p] = it.level;
      end
      OP_READ: begin
        if (in_range) r.read_level = dir_sent[p] ? input_image[p] : out_sent[p];
      end
      OP_BUS_TURN: begin
        if (dir_pending != dir_sent) begin
          dir_sent = dir_pending;
          r.dir_write_valid = 1'b1;
          r.dir_write_value = dir_sent;
        end
        if (out_pending != out_sent) begin
          out_sent = out_pending;
          r.out_write_valid = 1'b1;
          r.out_write_value = out_sent;
        end
        due = use_irq ? it.interrupt_low : (it.now_us >= next_read_us);
        if (due) begin
          r.read_request = 1'b1;
          next_read_us = it.now_us + TIME_W'(poll_us);
        end
        r.bus_busy = r.dir_write_valid | r.out_write_valid | r.read_request;
      end
      OP_INPUT_RX: begin
        if (it.read_ok) input_image = it.input_word;
      end
      OP_SET_ENABLE: begin
        outputs_on = it.enable;
        dir_pending = it.enable ? port_modes : ALL_INPUTS;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    in_item_t beat;
    result_t  want;
    result_t  got;
    if (!rst_n) begin
      use_irq      = 1'b0;
      poll_us      = POLL_RESET;
      claimed      = '0;
      claimed_out  = '0;
      port_modes   = ALL_INPUTS;
      outputs_on   = 1'b0;
      dir_pending  = ALL_INPUTS;
      dir_sent     = ALL_INPUTS;
      out_pending  = '0;
      out_sent     = '0;
      input_image  = '0;
      next_read_us = '0;
      results_due.delete();
    end else begin
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        case (cfg_mon.index)
          CFG_INITIAL_OUTPUT: begin
            out_pending = cfg_mon.data[WORD_W-1:0];
            out_sent    = cfg_mon.data[WORD_W-1:0];
          end
          CFG_USE_INTERRUPT: use_irq = cfg_mon.data[0];
          CFG_POLL_INTERVAL: poll_us = cfg_mon.data[POLL_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got.status          = status_t'(out_mon.status);
        got.read_level      = out_mon.read_level;
        got.dir_write_valid = out_mon.dir_write_valid;
        got.dir_write_value = out_mon.dir_write_value;
        got.out_write_valid = out_mon.out_write_valid;
        got.out_write_value = out_mon.out_write_value;
        got.read_request    = out_mon.read_request;
        got.bus_busy        = out_mon.bus_busy;
        if (results_due.size() == 0) begin
          $error("Result beat arrived with no prediction waiting.");
          errs++;
        end else begin
          want = results_due.pop_front();
          check_field("status", WORD_W'(want.status), WORD_W'(got.status));
          check_field("read_level", WORD_W'(want.read_level), WORD_W'(got.read_level));
          check_field("dir_write_valid", WORD_W'(want.dir_write_valid),
                      WORD_W'(got.dir_write_valid));
          check_field("dir_write_value", want.dir_write_value, got.dir_write_value);
          check_field("out_write_valid", WORD_W'(want.out_write_valid),
                      WORD_W'(got.out_write_valid));
          check_field("out_write_value", want.out_write_value, got.out_write_value);
          check_field("read_request", WORD_W'(want.read_request),
                      WORD_W'(got.read_request));
          check_field("bus_busy", WORD_W'(want.bus_busy), WORD_W'(got.bus_busy));
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        beat.op            = op_t'(in_mon.op);
        beat.port          = in_mon.port;
        beat.as_output     = in_mon.as_output;
        beat.level         = in_mon.level;
        beat.enable        = in_mon.enable;
        beat.input_word    = in_mon.input_word;
        beat.read_ok       = in_mon.read_ok;
        beat.interrupt_low = in_mon.interrupt_low;
        beat.now_us        = in_mon.now_us;
        results_due.push_back(shadow_step(beat));
      end
    end
    due_count = results_due.size();
  end

endmodule

[tb/io_expander_shadow_manager_top_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the I/O expander shadow manager: clock, reset, directed and
// random operation beats, configuration phases, result stalls and the verdict.
// Depends on iesm_pkg, the channel interfaces, the block and its checker.

module io_expander_shadow_manager_top_tb;
  import iesm_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 190;

  logic              clk;
  logic              rst_n;
  logic              idle_on;
  logic [TIME_W-1:0] clock_us;
  logic [POLL_W-1:0] poll_now;
  int unsigned       fail_count;
  int unsigned       pending;

  iesm_in_if  in_bus ();
  iesm_out_if out_bus ();
  iesm_cfg_if cfg_bus ();

  io_expander_shadow_manager_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  io_expander_shadow_manager_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_mon    (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    out_bus.ready <= 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_bus.ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t beat_of(op_t op, logic [PORT_W-1:0] port, logic flag,
                                       logic [TIME_W-1:0] value);
    in_item_t it;
    it.op            = op;
    it.port          = port;
    it.as_output     = flag;
    it.level         = flag;
    it.enable        = flag;
    it.read_ok       = flag;
    it.interrupt_low = flag;
    it.input_word    = value[WORD_W-1:0];
    it.now_us        = value;
    return it;
  endfunction

  function automatic logic [TIME_W-1:0] next_turn_time();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    if ($urandom_range(0, 15) == 0) clock_us = w[TIME_W-1:0];
    else clock_us = clock_us + TIME_W'($urandom_range(0, 2 * 32'(poll_now)));
    return clock_us;
  endfunction

  function automatic in_item_t random_beat();
    in_item_t    it;
    logic [31:0] r;
    logic [63:0] w;
    int unsigned pick;
    r = $urandom();
    w = {$urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) it.port = PORT_W'($urandom_range(16, 31));
    else it.port = PORT_W'($urandom_range(0, 15));
    it.as_output     = r[0];
    it.level         = r[1];
    it.enable        = r[2];
    it.interrupt_low = r[3];
    it.read_ok       = (r[7:4] != 4'd0);
    it.input_word    = r[31:16];
    it.now_us        = w[TIME_W-1:0];
    if (pick < 6) it.op = OP_CLAIM;
    else if (pick < 30) it.op = OP_WRITE;
    else if (pick < 55) it.op = OP_READ;
    else if (pick < 75) it.op = OP_BUS_TURN;
    else if (pick < 87) it.op = OP_INPUT_RX;
    else if (pick < 97) it.op = OP_SET_ENABLE;
    else it.op = op_t'(r[8] ? OP_SPARE_7 : OP_SPARE_6);
    if (it.op == OP_BUS_TURN) it.now_us = next_turn_time();
    return it;
  endfunction

  task automatic send_op(in_item_t it);
    @(negedge clk);
    in_bus.valid         <= 1'b1;
    in_bus.op            <= it.op;
    in_bus.port          <= it.port;
    in_bus.as_output     <= it.as_output;
    in_bus.level         <= it.level;
    in_bus.enable        <= it.enable;
    in_bus.input_word    <= it.input_word;
    in_bus.read_ok       <= it.read_ok;
    in_bus.interrupt_low <= it.interrupt_low;
    in_bus.now_us        <= it.now_us;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 16)) @(negedge clk) in_bus.valid <= 1'b0;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_poll(logic [POLL_W-1:0] us);
    write_reg(CFG_POLL_INTERVAL, us);
    poll_now = us;
  endtask

  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // A typical driver sequence: claim a port, enable outputs, set a level,
  // push it out on a bus turn and read the port back.
  task automatic port_session();
    in_item_t          it;
    logic [PORT_W-1:0] p;
    p = PORT_W'($urandom_range(0, 15));
    it = beat_of(OP_CLAIM, p, ($urandom_range(0, 3) != 0), '0);
    send_op(it);
    send_op(beat_of(OP_SET_ENABLE, p, 1'b1, '0));
    it = beat_of(OP_WRITE, p, 1'($urandom_range(0, 1)), '0);
    send_op(it);
    it = beat_of(OP_BUS_TURN, p, 1'($urandom_range(0, 1)), next_turn_time());
    send_op(it);
    send_op(beat_of(OP_READ, p, 1'b0, '0));
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    int unsigned hold_at;
    rst_n                <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.op            <= '0;
    in_bus.port          <= '0;
    in_bus.as_output     <= 1'b0;
    in_bus.level         <= 1'b0;
    in_bus.enable        <= 1'b0;
    in_bus.input_word    <= '0;
    in_bus.read_ok       <= 1'b0;
    in_bus.interrupt_low <= 1'b0;
    in_bus.now_us        <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= '0;
    cfg_bus.data         <= '0;
    idle_on  = 1'b1;
    clock_us = '0;
    poll_now = POLL_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    send_op(beat_of(OP_READ, 5'd0, 1'b0, 48'd0));
    send_op(beat_of(OP_INPUT_RX, 5'd0, 1'b0, 48'hFFFF));
    send_op(beat_of(OP_READ, 5'd15, 1'b0, 48'd0));
    send_op(beat_of(OP_INPUT_RX, 5'd0, 1'b1, 48'hFFFF));
    send_op(beat_of(OP_READ, 5'd15, 1'b0, 48'd0));
    send_op(beat_of(OP_CLAIM, 5'd31, 1'b1, 48'd0));
    send_op(beat_of(OP_CLAIM, 5'd16, 1'b0, 48'd0));
    send_op(beat_of(OP_CLAIM, 5'd3, 1'b0, 48'd0));
    send_op(beat_of(OP_CLAIM, 5'd3, 1'b0, 48'd0));
    send_op(beat_of(OP_CLAIM, 5'd3, 1'b1, 48'd0));
    send_op(beat_of(OP_CLAIM, 5'd0, 1'b1, 48'd0));
    send_op(beat_of(OP_CLAIM, 5'd0, 1'b0, 48'd0));
    send_op(beat_of(OP_CLAIM, 5'd15, 1'b1, 48'd0));
    send_op(beat_of(OP_WRITE, 5'd0, 1'b1, 48'd0));
    send_op(beat_of(OP_WRITE, 5'd15, 1'b1, 48'd0));
    send_op(beat_of(OP_WRITE, 5'd20, 1'b1, 48'd0));
    send_op(beat_of(OP_READ, 5'd20, 1'b0, 48'd0));
    send_op(beat_of(OP_BUS_TURN, 5'd0, 1'b0, 48'd0));
    send_op(beat_of(OP_SET_ENABLE, 5'd0, 1'b1, 48'd0));
    send_op(beat_of(OP_BUS_TURN, 5'd0, 1'b0, 48'd5));
    send_op(beat_of(OP_READ, 5'd0, 1'b0, 48'd0));
    send_op(beat_of(OP_READ, 5'd31, 1'b0, 48'd0));
    send_op(beat_of(OP_BUS_TURN, 5'd0, 1'b0, '1));
    send_op(beat_of(op_t'(OP_SPARE_6), 5'd31, 1'b1, '1));
    send_op(beat_of(op_t'(OP_SPARE_7), 5'd31, 1'b1, '1));
    send_op(beat_of(OP_SET_ENABLE, 5'd0, 1'b0, 48'd0));
    send_op(beat_of(OP_BUS_TURN, 5'd0, 1'b0, 48'd999));

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_INITIAL_OUTPUT, 20'h0FFFF);
          write_reg(CFG_USE_INTERRUPT, 20'd0);
          set_poll(20'd1);
        end
        1: write_reg(CFG_USE_INTERRUPT, 20'd1);
        2: begin
          write_reg(CFG_INITIAL_OUTPUT, 20'd0);
          write_reg(CFG_USE_INTERRUPT, 20'd0);
          set_poll(20'd1000000);
        end
        3: begin
          write_reg(CFG_INITIAL_OUTPUT, CFG_DATA_W'($urandom()));
          set_poll(POLL_W'($urandom_range(1, 1000000)));
        end
        4: begin
          write_reg(CFG_USE_INTERRUPT, 20'd1);
          write_reg(CFG_INITIAL_OUTPUT, CFG_DATA_W'($urandom()));
        end
        default: begin
          write_reg(CFG_USE_INTERRUPT, CFG_DATA_W'($urandom()));
          set_poll(POLL_W'($urandom_range(1, 5000)));
        end
      endcase
      idle_on = (ph != 2) && (ph != PHASES - 1);
      hold_at = $urandom_range(20, PHASE_ITEMS - 20);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if (hold_at != 0 && n >= hold_at) begin
          drain();
          hold_at = 0;
        end
        if ($urandom_range(0, 3) == 0) begin
          port_session();
          n += 5;
        end else begin
          send_op(random_beat());
          n++;
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
